>>> src/bfsa_pkg.sv
// Shared constants, types and command/status bundles of the best-fit segment allocator.
package bfsa_pkg;

  localparam int unsigned MaxUnitsDef = 16;
  localparam int unsigned MaxSegs     = 4;
  localparam int unsigned SegFields   = 4;
  localparam int unsigned AddrBits    = 16;
  localparam int unsigned TimeBits    = 32;
  localparam int unsigned OwnerBits   = 8;
  localparam int unsigned LifeBits    = 16;
  localparam int unsigned SegCntBits  = 3;
  localparam int unsigned FreedBits   = 5;
  localparam int unsigned StatusBits  = 2;
  localparam int unsigned InDataBits  = 96;
  localparam int unsigned OutDataBits = 72;

  // Result status codes
  localparam logic [StatusBits-1:0] StPlaced  = 2'd0;
  localparam logic [StatusBits-1:0] StNoFit   = 2'd1;
  localparam logic [StatusBits-1:0] StFull    = 2'd2;
  localparam logic [StatusBits-1:0] StTick    = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_step;
    logic apply;
    logic commit;
    logic fail_nofit;
    logic fail_full;
    logic tick_step;
    logic tick_end;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_tick;
    logic seg_done;
    logic size_zero;
    logic scan_last;
    logic found;
    logic need_split;
    logic full;
    logic tick_last;
    logic out_free;
  } stat_t;

endpackage

>>> src/bfsa_ctrl.sv
// Sequencing state machine of the best-fit segment allocator.
module bfsa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bfsa_pkg::stat_t  stat_i,
  output bfsa_pkg::cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PCHK = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_TICK = 3'd4;
  localparam logic [2:0] S_TEND = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.is_tick ? S_TICK : S_PCHK;
        end
      end
      S_PCHK: begin
        if (stat_i.seg_done) begin
          cmd_o.commit = 1'b1;
          state_d      = S_DONE;
        end else if (stat_i.size_zero) begin
          cmd_o.fail_nofit = 1'b1;
          state_d          = S_DONE;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (!stat_i.found) begin
          cmd_o.fail_nofit = 1'b1;
          state_d          = S_DONE;
        end else if (stat_i.need_split && stat_i.full) begin
          cmd_o.fail_full = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.apply = 1'b1;
          state_d     = S_PCHK;
        end
      end
      S_TICK: begin
        cmd_o.tick_step = 1'b1;
        if (stat_i.tick_last) state_d = S_TEND;
      end
      S_TEND: begin
        cmd_o.tick_end = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/bfsa_dp.sv
// Unit table, scratch copy, scan registers and result register of the allocator.
module bfsa_dp #(
  parameter int unsigned MaxUnits = bfsa_pkg::MaxUnitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bfsa_pkg::AddrBits-1:0]        cfg_data_i,
  input  logic [bfsa_pkg::InDataBits-1:0]      in_data_i,
  input  logic                                 in_op_i,
  input  bfsa_pkg::cmd_t                       cmd_i,
  output bfsa_pkg::stat_t                      stat_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [bfsa_pkg::OutDataBits-1:0]     out_data_o,
  output logic [bfsa_pkg::StatusBits-1:0]      out_status_o
);

  localparam int unsigned IW = (MaxUnits > 1) ? $clog2(MaxUnits) : 1;
  localparam int unsigned CW = $clog2(MaxUnits + 1);
  localparam int unsigned AW = bfsa_pkg::AddrBits;
  localparam int unsigned TW = bfsa_pkg::TimeBits;
  localparam int unsigned OW = bfsa_pkg::OwnerBits;
  localparam int unsigned NS = bfsa_pkg::SegFields;
  localparam int unsigned SW = bfsa_pkg::SegCntBits;
  localparam int unsigned FW = bfsa_pkg::FreedBits;
  localparam int unsigned NMax = (bfsa_pkg::MaxSegs < NS) ? bfsa_pkg::MaxSegs : NS;

  // Committed table
  logic [MaxUnits-1:0] free_q;
  logic [AW-1:0]       start_q [MaxUnits];
  logic [AW-1:0]       size_q  [MaxUnits];
  logic [OW-1:0]       owner_q [MaxUnits];
  logic [TW-1:0]       exp_q   [MaxUnits];
  logic [CW-1:0]       count_q;
  logic [TW-1:0]       time_q;

  // Working copy for a place transaction
  logic [MaxUnits-1:0] sfree_q;
  logic [AW-1:0]       sstart_q [MaxUnits];
  logic [AW-1:0]       ssize_q  [MaxUnits];
  logic [OW-1:0]       sowner_q [MaxUnits];
  logic [TW-1:0]       sexp_q   [MaxUnits];
  logic [CW-1:0]       scount_q;

  // Item and scan registers
  logic                is_tick_q;
  logic [OW-1:0]       owner_item_q;
  logic [TW-1:0]       exp_item_q;
  logic [SW-1:0]       n_q;
  logic [SW-1:0]       seg_i_q;
  logic [AW-1:0]       seg_q [NS];
  logic [AW-1:0]       starts_q [NS];
  logic [IW-1:0]       idx_q;
  logic                found_q;
  logic [IW-1:0]       best_q;
  logic [AW-1:0]       bsize_q;
  logic [CW-1:0]       w_q;
  logic                last_free_q;
  logic [AW-1:0]       last_size_q;
  logic [CW-1:0]       freed_q;
  logic                occ_acc_q;
  logic                occ_q;
  logic [bfsa_pkg::StatusBits-1:0] res_q;

  // Output register
  logic                out_valid_q;
  logic [bfsa_pkg::OutDataBits-1:0] out_data_q;
  logic [bfsa_pkg::OutDataBits-1:0] out_data_d;
  logic [bfsa_pkg::StatusBits-1:0]  out_status_q;

  logic [SW-1:0]       cnt_in;
  logic [SW-1:0]       n_sat;
  logic [AW-1:0]       cur_seg;
  logic                split;
  logic [CW-1:0]       best_p1;
  logic [IW-1:0]       best_p1_i;
  logic                cand;
  logic                expired;
  logic                fi;
  logic                merge;
  logic [IW-1:0]       wi;
  logic [IW-1:0]       wm1;
  logic [AW-1:0]       merged;

  assign cnt_in  = in_data_i[26:24];
  assign n_sat   = (cnt_in > SW'(NMax)) ? SW'(NMax) : cnt_in;
  assign cur_seg = seg_q[seg_i_q[1:0]];
  assign split   = (bsize_q != cur_seg);
  assign best_p1 = CW'(best_q) + CW'(1);
  assign best_p1_i = best_q + IW'(1);

  // Best-fit candidate test on the scratch entry
  assign cand = sfree_q[idx_q] && (ssize_q[idx_q] >= cur_seg) &&
                (!found_q || (ssize_q[idx_q] < bsize_q));

  // Expiry and merge decision on the committed entry
  assign expired = !free_q[idx_q] && (exp_q[idx_q] == time_q);
  assign fi      = free_q[idx_q] || expired;
  assign merge   = (w_q != '0) && fi && last_free_q;
  assign wi      = w_q[IW-1:0];
  assign wm1     = wi - IW'(1);
  assign merged  = last_size_q + size_q[idx_q];

  always_comb begin
    stat_o            = '0;
    stat_o.is_tick    = in_op_i;
    stat_o.seg_done   = (seg_i_q == n_q);
    stat_o.size_zero  = (cur_seg == '0);
    stat_o.scan_last  = ((CW'(idx_q) + CW'(1)) >= scount_q);
    stat_o.found      = found_q;
    stat_o.need_split = split;
    stat_o.full       = (scount_q >= CW'(MaxUnits));
    stat_o.tick_last  = ((CW'(idx_q) + CW'(1)) >= count_q);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Committed table control fields: reinit, commit, compact
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= MaxUnits'(1);
      for (int k = 0; k < MaxUnits; k++) begin
        start_q[k] <= '0;
        size_q[k]  <= (k == 0) ? {AW{1'b1}} : '0;
      end
      count_q   <= CW'(1);
      time_q    <= '0;
    end else if (cfg_we_i) begin
      free_q[0]  <= 1'b1;
      start_q[0] <= '0;
      size_q[0]  <= cfg_data_i;
      count_q    <= CW'(1);
    end else if (cmd_i.commit) begin
      free_q  <= sfree_q;
      start_q <= sstart_q;
      size_q  <= ssize_q;
      count_q <= scount_q;
    end else if (cmd_i.tick_step) begin
      if (merge) begin
        size_q[wm1] <= merged;
      end else begin
        free_q[wi]  <= fi;
        start_q[wi] <= start_q[idx_q];
        size_q[wi]  <= size_q[idx_q];
      end
    end else if (cmd_i.tick_end) begin
      count_q <= w_q;
      time_q  <= time_q + TW'(1);
    end
  end

  // Committed owner and expiry
  always_ff @(posedge clk_i) begin
    if (!cfg_we_i && cmd_i.commit) begin
      owner_q <= sowner_q;
      exp_q   <= sexp_q;
    end else if (!cfg_we_i && cmd_i.tick_step && !merge) begin
      owner_q[wi] <= owner_q[idx_q];
      exp_q[wi]   <= exp_q[idx_q];
    end
  end

  // Scratch table: copy on load, best-fit allocation with a split where needed on apply
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sfree_q  <= free_q;
      sstart_q <= start_q;
      ssize_q  <= size_q;
      sowner_q <= owner_q;
      sexp_q   <= exp_q;
      scount_q <= count_q;
    end else if (cmd_i.apply) begin
      if (split) begin
        for (int k = 1; k < MaxUnits; k++) begin
          if ((CW'(k) > best_p1) && (CW'(k) <= scount_q)) begin
            sfree_q[k]  <= sfree_q[k-1];
            sstart_q[k] <= sstart_q[k-1];
            ssize_q[k]  <= ssize_q[k-1];
            sowner_q[k] <= sowner_q[k-1];
            sexp_q[k]   <= sexp_q[k-1];
          end
        end
        sfree_q[best_p1_i]  <= 1'b1;
        sstart_q[best_p1_i] <= sstart_q[best_q] + cur_seg;
        ssize_q[best_p1_i]  <= bsize_q - cur_seg;
        sowner_q[best_p1_i] <= '0;
        sexp_q[best_p1_i]   <= '0;
        scount_q            <= scount_q + CW'(1);
      end
      sfree_q[best_q]  <= 1'b0;
      ssize_q[best_q]  <= cur_seg;
      sowner_q[best_q] <= owner_item_q;
      sexp_q[best_q]   <= exp_item_q;
    end
  end

  // Item latch and per-segment bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      is_tick_q    <= in_op_i;
      owner_item_q <= in_data_i[7:0];
      exp_item_q   <= time_q + TW'(in_data_i[23:8]);
      n_q          <= n_sat;
      seg_i_q      <= '0;
      seg_q[0]     <= in_data_i[42:27];
      seg_q[1]     <= in_data_i[58:43];
      seg_q[2]     <= in_data_i[74:59];
      seg_q[3]     <= in_data_i[90:75];
      for (int k = 0; k < NS; k++) starts_q[k] <= '0;
      idx_q        <= '0;
      w_q          <= '0;
      last_free_q  <= 1'b0;
      last_size_q  <= '0;
      freed_q      <= '0;
      occ_acc_q    <= 1'b0;
    end else if (cmd_i.scan_init) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (cand) begin
        found_q <= 1'b1;
        best_q  <= idx_q;
        bsize_q <= ssize_q[idx_q];
      end
      idx_q <= idx_q + IW'(1);
    end else if (cmd_i.apply) begin
      starts_q[seg_i_q[1:0]] <= sstart_q[best_q];
      seg_i_q                <= seg_i_q + SW'(1);
    end else if (cmd_i.tick_step) begin
      if (merge) begin
        last_size_q <= merged;
      end else begin
        last_free_q <= fi;
        last_size_q <= size_q[idx_q];
        w_q         <= w_q + CW'(1);
      end
      freed_q   <= freed_q + CW'(expired);
      occ_acc_q <= occ_acc_q || !fi;
      idx_q     <= idx_q + IW'(1);
    end
  end

  // Result status and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= bfsa_pkg::StPlaced;
      occ_q <= 1'b0;
    end else begin
      if (cfg_we_i) occ_q <= 1'b0;
      else if (cmd_i.commit && (n_q != '0)) occ_q <= 1'b1;
      else if (cmd_i.tick_end) occ_q <= occ_acc_q;
      priority if (cmd_i.commit) res_q <= bfsa_pkg::StPlaced;
      else if (cmd_i.fail_nofit) res_q <= bfsa_pkg::StNoFit;
      else if (cmd_i.fail_full)  res_q <= bfsa_pkg::StFull;
      else if (cmd_i.tick_end)   res_q <= bfsa_pkg::StTick;
    end
  end

  // Output register: load on emit, drop on transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Assemble the result word
  always_comb begin
    out_data_d = '0;
    if (res_q == bfsa_pkg::StPlaced) begin
      out_data_d[15:0]  = starts_q[0];
      out_data_d[31:16] = starts_q[1];
      out_data_d[47:32] = starts_q[2];
      out_data_d[63:48] = starts_q[3];
    end
    if (is_tick_q) out_data_d[68:64] = FW'(freed_q);
    out_data_d[69] = (res_q == bfsa_pkg::StTick) ? occ_acc_q : occ_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= res_q;
      out_data_q   <= out_data_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;

`ifndef SYNTHESIS
  a_scount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> (scount_q <= CW'(MaxUnits)))
    else $error("scratch unit count beyond table depth");

  a_time_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.tick_end && !cfg_we_i) |=> (time_q == $past(time_q) + TW'(1)))
    else $error("time did not advance on tick");

  a_split_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && split) |=> (scount_q == $past(scount_q) + CW'(1)))
    else $error("split did not add one unit");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick_end |-> (w_q != '0))
    else $error("compaction left an empty table");
`endif

endmodule

>>> src/best_fit_segment_allocator.sv
// Top level of the best-fit segment allocator: stream ports, controller and datapath.
//
// One transaction in, one result out. A tick walks the unit table once; a place walks it
// once for each of its n segments, over the units that the table holds when that segment
// starts, one unit per cycle, to find the smallest fitting hole. Input is taken only when
// the block is idle, while a finished result may still wait in the output register.
// Writing the memory size resets the table to a single hole and keeps the time count;
// write it only while the block is idle.
module best_fit_segment_allocator #(
  parameter int unsigned MaxUnits = bfsa_pkg::MaxUnitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,       // total managed memory size
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // owner_id[7:0], lifetime[23:8], seg_count[26:24], seg_size_0..3 [42:27] [58:43] [74:59]
  // [90:75], zero fill above
  input  logic [95:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,   // op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // start_0[15:0], start_1[31:16], start_2[47:32], start_3[63:48], freed_units[68:64],
  // any_occupied[69], zero fill above
  output logic [71:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o    // status
);

  bfsa_pkg::cmd_t  cmd;
  bfsa_pkg::stat_t stat;

  bfsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bfsa_dp #(
    .MaxUnits (MaxUnits)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (s_axis_tdata_i),
    .in_op_i      (s_axis_tuser_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o)
  );

endmodule
